### rtl/core/skm_pkg.sv
// Package for the sequential k-way merge block.
// Holds the item types, sizes and codes shared by every rtl/core module.
`default_nettype none
package skm_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_ARRAYS   = 64;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LEN_W        = 13;
    localparam int ACNT_W       = 7;
    localparam int CMP_W        = 18;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CMP_W-1:0]  CMP_MAX     = {CMP_W{1'b1}};
    localparam logic [CNT_W-1:0]  MAX_ELEM_C  = CNT_W'(MAX_ELEMENTS);
    localparam logic [ACNT_W-1:0] MAX_ARR_C   = ACNT_W'(MAX_ARRAYS);

    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [IDX_W-1:0]         position;
        logic                     is_last;
        logic [CMP_W-1:0]         comparisons;
        logic [1:0]               status;
    } t_out_item;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] merged_count;
    } t_back_stat;

endpackage
`default_nettype wire

### rtl/core/skm_front.sv
// Front end of the merge block: a two-entry queue of accepted items.
// Depends on skm_pkg for the item type and command codes.
`default_nettype none
module skm_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire skm_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output logic              o_is_read,
    output skm_pkg::t_in_item o_item,
    input  wire               i_take
);

    skm_pkg::t_in_item r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              n_wp;
    logic              n_rp;
    logic [1:0]        n_cnt;
    logic              wr;
    logic              rd;

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_mem[r_rp];
    assign o_is_read = (r_mem[r_rp].cmd == skm_pkg::CMD_READ);
    assign wr        = i_push && !o_full;
    assign rd        = i_take && o_valid;

    always_comb begin
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

### rtl/core/skm_back.sv
// Back end of the merge block: staging and merged stores, the two-way merge
// sequencer and read-out. Depends on skm_pkg.
`default_nettype none
module skm_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [skm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [skm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                 i_valid,
    input  wire                                 i_is_read,
    input  wire skm_pkg::t_in_item              i_item,
    output logic                                o_take,
    output logic                                o_res_valid,
    output skm_pkg::t_out_item                  o_res,
    input  wire                                 i_res_ready,
    output skm_pkg::t_back_stat                 o_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_CMP   = 5'b00100,
        S_RDATA = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    localparam int IW = skm_pkg::IDX_W;
    localparam int CW = skm_pkg::CNT_W;
    localparam int DW = skm_pkg::DATA_W;

    logic [DW-1:0] r_merged [2*skm_pkg::MAX_ELEMENTS];
    logic [DW-1:0] r_stage  [skm_pkg::MAX_ELEMENTS];

    t_state                      r_state;
    logic [skm_pkg::LEN_W-1:0]   r_len;
    logic [skm_pkg::ACNT_W-1:0]  r_acnt;
    logic [CW-1:0]               r_mc;
    logic [CW-1:0]               r_loaded;
    logic [skm_pkg::ACNT_W-1:0]  r_done;
    logic [skm_pkg::CMP_W-1:0]   r_cmp;
    logic [IW-1:0]               r_rptr;
    logic                        r_bank;
    logic [CW-1:0]               r_i;
    logic [CW-1:0]               r_j;
    logic [DW-1:0]               r_a_data;
    logic [DW-1:0]               r_b_data;
    logic signed [DW-1:0]        r_vres;
    logic [IW-1:0]               r_pos;
    logic                        r_last;
    logic [1:0]                  r_status;

    logic [skm_pkg::LEN_W-1:0]   eff_len;
    logic [skm_pkg::ACNT_W-1:0]  eff_cnt;
    logic                        complete;
    logic [IW-1:0]               rp_eff;
    logic [IW:0]                 rd_addr;
    logic [CW:0]                 cap_sum;
    logic [CW-1:0]               loaded_inc;
    logic                        a_left;
    logic                        b_left;
    logic                        take_a;
    logic [CW-1:0]               k_idx;
    logic                        wr_merged;
    logic [DW-1:0]               wr_data;
    logic                        wr_stage;

    always_comb begin
        eff_len  = (r_len == '0) ? skm_pkg::LEN_W'(1) : r_len;
        if (r_acnt == '0) begin
            eff_cnt = skm_pkg::ACNT_W'(1);
        end else if (r_acnt > skm_pkg::MAX_ARR_C) begin
            eff_cnt = skm_pkg::MAX_ARR_C;
        end else begin
            eff_cnt = r_acnt;
        end
        complete   = (r_done >= eff_cnt);
        rp_eff     = ({1'b0, r_rptr} >= r_mc) ? '0 : r_rptr;
        cap_sum    = {1'b0, r_mc} + {1'b0, r_loaded} + (CW+1)'(1);
        loaded_inc = r_loaded + CW'(1);
        a_left     = (r_i < r_mc);
        b_left     = (r_j < CW'(eff_len));
        // Stable merge: on equal keys the element already merged goes first.
        take_a     = a_left && (!b_left || ($signed(r_a_data) <= $signed(r_b_data)));
        k_idx      = r_i + r_j;
        wr_merged  = (r_state == S_CMP);
        wr_data    = take_a ? r_a_data : r_b_data;
        wr_stage   = (r_state == S_IDLE) && i_valid && !i_is_read && !complete
                     && (cap_sum <= {1'b0, skm_pkg::MAX_ELEM_C});
        rd_addr    = (r_state == S_FETCH) ? {r_bank, r_i[IW-1:0]} : {r_bank, rp_eff};
    end

    assign o_take      = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = '{value_res: r_vres, position: r_pos, is_last: r_last,
                           comparisons: r_cmp, status: r_status};
    assign o_stat      = '{busy: (r_state != S_IDLE), merged_count: r_mc};

    always_ff @(posedge i_clk) begin
        r_a_data <= r_merged[rd_addr];
        r_b_data <= r_stage[r_j[IW-1:0]];
        if (wr_merged) begin
            r_merged[{~r_bank, k_idx[IW-1:0]}] <= wr_data;
        end
        if (wr_stage) begin
            r_stage[r_loaded[IW-1:0]] <= i_item.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= skm_pkg::LEN_W'(1);
            r_acnt   <= skm_pkg::ACNT_W'(1);
            r_mc     <= '0;
            r_loaded <= '0;
            r_done   <= '0;
            r_cmp    <= '0;
            r_rptr   <= '0;
            r_bank   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == skm_pkg::CFG_LEN) begin
                r_len <= i_cfg_data[skm_pkg::LEN_W-1:0];
            end else begin
                r_acnt <= i_cfg_data[skm_pkg::ACNT_W-1:0];
            end
            r_state  <= S_IDLE;
            r_mc     <= '0;
            r_loaded <= '0;
            r_done   <= '0;
            r_cmp    <= '0;
            r_rptr   <= '0;
            r_bank   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_vres   <= '0;
                        r_pos    <= '0;
                        r_last   <= 1'b0;
                        r_status <= skm_pkg::ST_OK;
                        if (i_is_read) begin
                            if (!complete || r_mc == '0) begin
                                r_status <= skm_pkg::ST_NOT_READY;
                                r_state  <= S_RESP;
                            end else begin
                                r_state <= S_RDATA;
                            end
                        end else if (!wr_stage) begin
                            r_status <= skm_pkg::ST_OVERFLOW;
                            r_state  <= S_RESP;
                        end else if (loaded_inc >= CW'(eff_len)) begin
                            r_loaded <= loaded_inc;
                            r_i      <= '0;
                            r_j      <= '0;
                            r_state  <= S_FETCH;
                        end else begin
                            r_loaded <= loaded_inc;
                            r_state  <= S_RESP;
                        end
                    end
                end
                S_FETCH: begin
                    if (!a_left && !b_left) begin
                        r_bank   <= ~r_bank;
                        r_mc     <= r_mc + CW'(eff_len);
                        r_done   <= r_done + skm_pkg::ACNT_W'(1);
                        r_loaded <= '0;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (a_left && b_left && r_cmp != skm_pkg::CMP_MAX) begin
                        r_cmp <= r_cmp + skm_pkg::CMP_W'(1);
                    end
                    if (take_a) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                    r_state <= S_FETCH;
                end
                S_RDATA: begin
                    r_vres <= r_a_data;
                    r_pos  <= rp_eff;
                    if ({1'b0, rp_eff} + CW'(1) >= r_mc) begin
                        r_last <= 1'b1;
                        r_rptr <= '0;
                    end else begin
                        r_rptr <= rp_eff + IW'(1);
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/sequential_k_way_merge.sv
// Sequential k-way merge. The push that completes an array starts a merge of the
// staged array into the merged elements, where each merged element takes a store
// read and a write.
// Items are handled one at a time; two queue at the input, one result at the output.
// Synchronous active-low reset empties both queues and restarts the job; a
// configuration write restarts the job only. Store contents are not reset.
`default_nettype none
module sequential_k_way_merge (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [skm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [skm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           push,
    input  wire skm_pkg::t_in_item        i_in_item,
    output logic                          full,
    output logic                          empty,
    input  wire                           pop,
    output skm_pkg::t_out_item            o_out_item
);

    logic                f_valid;
    logic                f_is_read;
    skm_pkg::t_in_item   f_item;
    logic                b_take;
    logic                b_res_valid;
    skm_pkg::t_out_item  b_res;
    skm_pkg::t_back_stat b_stat;
    logic                res_ready;
    logic                r_out_valid;
    skm_pkg::t_out_item  r_out;

    skm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .o_full   (full),
        .o_valid  (f_valid),
        .o_is_read(f_is_read),
        .o_item   (f_item),
        .i_take   (b_take)
    );

    skm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (f_valid),
        .i_is_read  (f_is_read),
        .i_item     (f_item),
        .o_take     (b_take),
        .o_res_valid(b_res_valid),
        .o_res      (b_res),
        .i_res_ready(res_ready),
        .o_stat     (b_stat)
    );

    assign res_ready  = !r_out_valid || pop;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= b_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && b_res_valid) begin
            r_out <= b_res;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status != skm_pkg::ST_OK) |->
        (o_out_item.value_res == '0 && o_out_item.position == '0 && !o_out_item.is_last))
        else $error("error item carries element data");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.merged_count <= skm_pkg::MAX_ELEM_C)
        else $error("merged count beyond capacity");

    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_take) |-> !b_stat.busy)
        else $error("item taken while back end busy");

endmodule
`default_nettype wire

### tb/sv/tb_sequential_k_way_merge.sv
// Self-checking testbench for the sequential k-way merge block.
// Depends on skm_pkg and sequential_k_way_merge, with its skm_front and skm_back.
// A local merge predictor computes every expected result item.
`default_nettype none
module tb_sequential_k_way_merge;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 40;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [skm_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = skm_pkg::CFG_LEN;
    logic [skm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           push       = 1'b0;
    skm_pkg::t_in_item              i_in_item  = '0;
    logic                           pop        = 1'b0;
    logic                           full;
    logic                           empty;
    skm_pkg::t_out_item             o_out_item;

    sequential_k_way_merge dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .i_in_item (i_in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Merge predictor state.
    logic signed [skm_pkg::DATA_W-1:0] merged_mem [2][skm_pkg::MAX_ELEMENTS];
    logic signed [skm_pkg::DATA_W-1:0] staged_mem [skm_pkg::MAX_ELEMENTS];
    int unsigned merged_n, staged_n, arrays_in, cmp_total, read_idx;
    bit          bank;
    int unsigned len_reg = 1, count_reg = 1;

    skm_pkg::t_out_item pending_results [$];
    int unsigned errors = 0, items_sent = 0, results_seen = 0, jobs_run = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;
    int          pop_wait = 0;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void restart_job();
        merged_n  = 0;
        staged_n  = 0;
        arrays_in = 0;
        cmp_total = 0;
        read_idx  = 0;
        bank      = 1'b0;
    endfunction

    function automatic void fold_staged(int unsigned len);
        int unsigned i, j, k;
        bit src, dst;
        src = bank;
        dst = ~bank;
        i = 0; j = 0; k = 0;
        if (arrays_in == 0) begin
            for (j = 0; j < len; j++) merged_mem[src][j] = staged_mem[j];
        end else begin
            while (i < merged_n && j < len) begin
                if (cmp_total < skm_pkg::CMP_MAX) cmp_total++;
                // Stable: on equal keys the element already merged goes first.
                if (merged_mem[src][i] <= staged_mem[j])
                    merged_mem[dst][k++] = merged_mem[src][i++];
                else merged_mem[dst][k++] = staged_mem[j++];
            end
            while (i < merged_n) merged_mem[dst][k++] = merged_mem[src][i++];
            while (j < len) merged_mem[dst][k++] = staged_mem[j++];
            bank = dst;
        end
        merged_n += len;
        arrays_in++;
        staged_n = 0;
    endfunction

    function automatic skm_pkg::t_out_item merge_step(skm_pkg::t_in_item it);
        skm_pkg::t_out_item res;
        int unsigned        len, cnt;
        bit                 done;
        res = '0;
        len = (len_reg == 0) ? 1 : len_reg;
        cnt = (count_reg == 0) ? 1 : count_reg;
        if (cnt > skm_pkg::MAX_ARRAYS) cnt = skm_pkg::MAX_ARRAYS;
        done = (arrays_in >= cnt);
        if (it.cmd == skm_pkg::CMD_PUSH) begin
            if (done || merged_n + staged_n + 1 > skm_pkg::MAX_ELEMENTS) begin
                res.status = skm_pkg::ST_OVERFLOW;
            end else begin
                staged_mem[staged_n] = it.value;
                staged_n++;
                if (staged_n >= len) fold_staged(len);
            end
        end else if (!done || merged_n == 0) begin
            res.status = skm_pkg::ST_NOT_READY;
        end else begin
            if (read_idx >= merged_n) read_idx = 0;
            res.value_res = merged_mem[bank][read_idx];
            res.position  = read_idx[skm_pkg::IDX_W-1:0];
            if (read_idx + 1 >= merged_n) begin
                res.is_last = 1'b1;
                read_idx = 0;
            end else begin
                read_idx++;
            end
        end
        res.comparisons = cmp_total[skm_pkg::CMP_W-1:0];
        return res;
    endfunction

    task automatic send_item(logic cmd, logic signed [skm_pkg::DATA_W-1:0] value);
        int unsigned       gap;
        skm_pkg::t_in_item it;
        gap = gap_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.cmd   = cmd;
        it.value = value;
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        pending_results.push_back(merge_step(it));
        items_sent++;
    endtask

    task automatic push_value(logic signed [skm_pkg::DATA_W-1:0] value);
        send_item(skm_pkg::CMD_PUSH, value);
    endtask

    task automatic read_next();
        send_item(skm_pkg::CMD_READ, $urandom);
    endtask

    // Waits until the block is idle, then writes one register.
    task automatic write_reg(logic [skm_pkg::CFG_IDX_W-1:0] idx,
                             logic [skm_pkg::CFG_DATA_W-1:0] data);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == skm_pkg::CFG_LEN) len_reg = data;
        else count_reg = data[skm_pkg::ACNT_W-1:0];
        restart_job();
    endtask

    task automatic setup_job(int unsigned len, int unsigned cnt);
        write_reg(skm_pkg::CFG_LEN, len[skm_pkg::CFG_DATA_W-1:0]);
        write_reg(skm_pkg::CFG_COUNT, {6'($urandom), cnt[skm_pkg::ACNT_W-1:0]});
        jobs_run++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        skm_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item %h", $time, o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item !== want) begin
                    errors++;
                    $display("%0t: mismatch exp val=%0d pos=%0d last=%0b cmp=%0d st=%0d",
                             $time, want.value_res, want.position, want.is_last,
                             want.comparisons, want.status);
                    $display("%0t:          got val=%0d pos=%0d last=%0b cmp=%0d st=%0d",
                             $time, o_out_item.value_res, o_out_item.position,
                             o_out_item.is_last, o_out_item.comparisons, o_out_item.status);
                end
            end
        end
    end

    // Result side stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait <= pop_wait - 1;
        end else begin
            pop <= 1'b1;
            if (pop && !empty) pop_wait <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        read_next();
        push_value(32'sd5);
        read_next();
        read_next();
        push_value(-32'sd7);
    endtask

    task automatic test_degenerate_config();
        setup_job(0, 0);
        push_value(32'h8000_0000);
        read_next();
        push_value(32'h7FFF_FFFF);
        // The largest length register value, with a few pushes only.
        setup_job(8191, 1);
        push_value(32'hFFFF_FFFF);
        push_value(32'sd0);
        read_next();
    endtask

    task automatic test_small_merge();
        setup_job(3, 3);
        push_value(-32'sd1);
        push_value(32'sd0);
        push_value(32'h7FFF_FFFF);
        read_next();
        push_value(32'h8000_0000);
        push_value(32'sd0);
        push_value(32'h7FFF_FFFF);
        push_value(-32'sd1);
        push_value(-32'sd1);
        push_value(32'sd0);
        repeat (10) read_next();
        push_value(32'sd3);
    endtask

    task automatic fill_job(int unsigned len, int unsigned cnt, int unsigned extra_reads);
        logic signed [skm_pkg::DATA_W-1:0] vals [$];
        int unsigned narrow;
        for (int a = 0; a < cnt; a++) begin
            vals.delete();
            narrow = $urandom_range(0, 2);
            for (int e = 0; e < len; e++)
                vals.push_back(narrow == 0 ? $signed(32'($urandom_range(0, 7)) - 4)
                                           : $urandom);
            if ($urandom_range(0, 9) != 0) vals.sort();
            foreach (vals[e]) begin
                if ($urandom_range(0, 40) == 0) read_next();
                push_value(vals[e]);
            end
        end
        repeat (len * cnt + extra_reads) read_next();
        if ($urandom_range(0, 3) == 0) push_value($urandom);
    endtask

    task automatic test_count_limit();
        setup_job(1, 127);
        fill_job(1, skm_pkg::MAX_ARRAYS, 2);
        setup_job(1, skm_pkg::MAX_ARRAYS);
        fill_job(1, skm_pkg::MAX_ARRAYS, 0);
    endtask

    task automatic test_random_jobs();
        int unsigned r, len, cnt;
        while (items_sent < 1500) begin
            quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(1, 8);
                cnt = $urandom_range(2, 8);
            end else if (r < 90) begin
                len = $urandom_range(1, 3);
                cnt = $urandom_range(20, 64);
            end else begin
                len = $urandom_range(9, 40);
                cnt = $urandom_range(1, 4);
            end
            setup_job(len, cnt);
            fill_job(len, cnt, $urandom_range(0, 3));
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_degenerate_config();
        test_small_merge();
        test_count_limit();
        test_random_jobs();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d jobs, %0d items sent, %0d result items checked.",
                 jobs_run, items_sent, results_seen);
        $display("Included clamped and zero settings, stable ties and wrapped reads.");
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
